### rtl/sliver_triangle_detector_assert.svh
// Assertion macros shared by the sliver triangle detector RTL.
`ifndef SLIVER_TRIANGLE_DETECTOR_ASSERT_SVH
`define SLIVER_TRIANGLE_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define STDET_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stdet: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define STDET_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stdet: next-cycle check failed");

`endif

### rtl/stdet_pkg.sv
// Widths and constants of the sliver triangle detector.
`default_nettype none
package stdet_pkg;
   localparam int ID_W       = 24;
   localparam int COORD_W    = 32;
   localparam int VALUE_W    = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int KLO_W      = 34;
   localparam int KHI_W      = CROSS_W - KLO_W;
   localparam int AREA_W     = 68;
   localparam int KSQ_W      = 2 * AREA_W;
   localparam int AREA_REM_W = AREA_W + 3;
   localparam int ESQ_W      = PROD_W + 2;
   localparam int EDGE_W     = ESQ_W / 2;
   localparam int EDGE_REM_W = EDGE_W + 3;
   localparam int PERIM_W    = EDGE_W + 2;
   localparam int DIV_REM_W  = PERIM_W + 1;
   localparam logic [VALUE_W-1:0] THRESHOLD_RESET = VALUE_W'(256);

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
endpackage
`default_nettype wire

### rtl/stdet_req_if.sv
// Triangle request channel: valid, ready and the face payload.
`default_nettype none
interface stdet_req_if;
   import stdet_pkg::*;
   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    face_id;
   logic [COORD_W-1:0] ax;
   logic [COORD_W-1:0] ay;
   logic [COORD_W-1:0] az;
   logic [COORD_W-1:0] bx;
   logic [COORD_W-1:0] by_coord;
   logic [COORD_W-1:0] bz;
   logic [COORD_W-1:0] cx;
   logic [COORD_W-1:0] cy;
   logic [COORD_W-1:0] cz;
   modport source (output valid, face_id, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                   input ready);
   modport sink (input valid, face_id, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                 output ready);
endinterface
`default_nettype wire

### rtl/stdet_rsp_if.sv
// Sliver response channel: valid, ready and the flagged face payload.
`default_nettype none
interface stdet_rsp_if;
   import stdet_pkg::*;
   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    sliver_id;
   logic [VALUE_W-1:0] sliver_value;
   modport source (output valid, sliver_id, sliver_value, input ready);
   modport sink (input valid, sliver_id, sliver_value, output ready);
endinterface
`default_nettype wire

### rtl/sliver_triangle_detector.sv
// Top level of the sliver triangle detector pipeline.
// Usage:
//   req_bus takes one triangle per transfer: face_id and vertices A, B, C.
//   rsp_bus returns face_id and inradius 2*area/perimeter for a face whose
//   inradius is at most the threshold and whose vertices are not collinear;
//   other faces produce no transfer.
//   csr_we/csr_wdata write the threshold (reset 256, 8 fraction bits).
// Timing:
//   One triangle per cycle while the output queue is not full. From request to
//   response: 5 arithmetic stages, 69 stages of the bit-per-stage square roots,
//   69 stages of the bit-per-stage divider, and a two-entry output queue.
// Reset: synchronous, clears every stage valid and the queue, threshold 256.
// Stall: while the output queue holds one result, requests keep flowing;
//   when it holds two, the whole pipeline and req_bus.ready hold until
//   rsp_bus drains an entry. Nothing is lost or repeated.
`default_nettype none
module sliver_triangle_detector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   stdet_req_if.sink                         req_bus,
   stdet_rsp_if.source                       rsp_bus,
   input  wire logic                         csr_we,
   input  wire logic [stdet_pkg::VALUE_W-1:0] csr_wdata
);
   import stdet_pkg::*;
`include "sliver_triangle_detector_assert.svh"

   typedef struct packed {
      logic [ID_W-1:0]            id;
      logic                       nz;
      logic [2:0][ESQ_W-1:0]      esq;
   } carry_type;

   function automatic prod_type sx(input diff_type d);
      return PROD_W'(d);
   endfunction

   logic en;
   logic [VALUE_W-1:0] thr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ptr_ff, wr_ptr_ff;
   logic [ID_W-1:0] f_id_ff [2];
   logic [VALUE_W-1:0] f_val_ff [2];

   assign en = (cnt_ff != 2'd2);
   assign req_bus.ready = en;

   // stage A: edge vectors
   logic a_v_ff;
   logic [ID_W-1:0] a_id_ff;
   diff_type a_u_ff [3], a_v3_ff [3], a_w_ff [3];

   // stage B: products
   logic b_v_ff;
   logic [ID_W-1:0] b_id_ff;
   prod_type b_p_ff [3], b_q_ff [3];
   logic [PROD_W-1:0] b_s_ff [3][3];
   prod_type b_p_in [3], b_q_in [3];
   logic [PROD_W-1:0] b_s_in [3][3];

   // stage C: cross terms and squared edges
   logic c_v_ff;
   carry_type c_car_ff, c_car_in;
   logic [CROSS_W-1:0] c_k_ff [3], c_k_in [3];
   logic [CROSS_W-1:0] k_diff [3];

   // stage D: partial squares
   logic d_v_ff;
   carry_type d_car_ff;
   logic [2*KHI_W-1:0] d_hh_ff [3], d_hh_in [3];
   logic [KHI_W+KLO_W-1:0] d_hl_ff [3], d_hl_in [3];
   logic [2*KLO_W-1:0] d_ll_ff [3], d_ll_in [3];

   // stage E: squares
   logic e_v_ff;
   carry_type e_car_ff;
   logic [KSQ_W-1:0] e_sq_ff [3], e_sq_in [3];

   // square root stages
   logic [AREA_W:0] sq_v_ff;
   logic [ID_W-1:0] sq_id_ff [AREA_W+1];
   logic [AREA_W:0] sq_nz_ff;
   logic [KSQ_W-1:0] sq_n_ff [AREA_W+1];
   logic [AREA_REM_W-1:0] sq_rem_ff [AREA_W+1];
   logic [AREA_W-1:0] sq_root_ff [AREA_W+1];
   logic [2:0][ESQ_W-1:0] er_n_ff [AREA_W+1];
   logic [2:0][EDGE_REM_W-1:0] er_rem_ff [AREA_W+1];
   logic [2:0][EDGE_W-1:0] er_root_ff [AREA_W+1];

   // divider stages
   logic [AREA_W:0] dv_v_ff;
   logic [ID_W-1:0] dv_id_ff [AREA_W+1];
   logic [AREA_W:0] dv_nz_ff;
   logic [AREA_W-1:0] dv_a_ff [AREA_W+1];
   logic [DIV_REM_W-1:0] dv_rem_ff [AREA_W+1];
   logic [AREA_W-1:0] dv_quo_ff [AREA_W+1];
   logic [PERIM_W-1:0] dv_d_ff [AREA_W+1];
   logic [PERIM_W-1:0] perim_in;

   logic fin_pass, push, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_p_in[i] = '0;
         b_q_in[i] = '0;
      end
      b_p_in[0] = sx(a_u_ff[1]) * sx(a_v3_ff[2]);
      b_q_in[0] = sx(a_u_ff[2]) * sx(a_v3_ff[1]);
      b_p_in[1] = sx(a_u_ff[2]) * sx(a_v3_ff[0]);
      b_q_in[1] = sx(a_u_ff[0]) * sx(a_v3_ff[2]);
      b_p_in[2] = sx(a_u_ff[0]) * sx(a_v3_ff[1]);
      b_q_in[2] = sx(a_u_ff[1]) * sx(a_v3_ff[0]);
      for (int i = 0; i < 3; i++) begin
         b_s_in[0][i] = PROD_W'(sx(a_u_ff[i]) * sx(a_u_ff[i]));
         b_s_in[1][i] = PROD_W'(sx(a_w_ff[i]) * sx(a_w_ff[i]));
         b_s_in[2][i] = PROD_W'(sx(a_v3_ff[i]) * sx(a_v3_ff[i]));
      end
   end

   always_comb begin
      c_car_in.id = b_id_ff;
      for (int i = 0; i < 3; i++) begin
         k_diff[i] = {b_p_ff[i][PROD_W-1], b_p_ff[i]} - {b_q_ff[i][PROD_W-1], b_q_ff[i]};
         c_k_in[i] = k_diff[i][CROSS_W-1] ? CROSS_W'(-k_diff[i]) : k_diff[i];
         c_car_in.esq[i] = ESQ_W'(b_s_ff[i][0]) + ESQ_W'(b_s_ff[i][1])
                         + ESQ_W'(b_s_ff[i][2]);
      end
      c_car_in.nz = (k_diff[0] != '0) || (k_diff[1] != '0) || (k_diff[2] != '0);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_hh_in[i] = c_k_ff[i][CROSS_W-1:KLO_W] * c_k_ff[i][CROSS_W-1:KLO_W];
         d_hl_in[i] = c_k_ff[i][CROSS_W-1:KLO_W] * c_k_ff[i][KLO_W-1:0];
         d_ll_in[i] = c_k_ff[i][KLO_W-1:0] * c_k_ff[i][KLO_W-1:0];
         e_sq_in[i] = (KSQ_W'(d_hh_ff[i]) << (2 * KLO_W))
                    + (KSQ_W'(d_hl_ff[i]) << (KLO_W + 1)) + KSQ_W'(d_ll_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_bus.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
         sq_v_ff[0] <= e_v_ff;
      end
      if (en) begin
         a_id_ff <= req_bus.face_id;
         a_u_ff[0] <= {req_bus.bx[COORD_W-1], req_bus.bx}
                    - {req_bus.ax[COORD_W-1], req_bus.ax};
         a_u_ff[1] <= {req_bus.by_coord[COORD_W-1], req_bus.by_coord}
                    - {req_bus.ay[COORD_W-1], req_bus.ay};
         a_u_ff[2] <= {req_bus.bz[COORD_W-1], req_bus.bz}
                    - {req_bus.az[COORD_W-1], req_bus.az};
         a_v3_ff[0] <= {req_bus.cx[COORD_W-1], req_bus.cx}
                     - {req_bus.ax[COORD_W-1], req_bus.ax};
         a_v3_ff[1] <= {req_bus.cy[COORD_W-1], req_bus.cy}
                     - {req_bus.ay[COORD_W-1], req_bus.ay};
         a_v3_ff[2] <= {req_bus.cz[COORD_W-1], req_bus.cz}
                     - {req_bus.az[COORD_W-1], req_bus.az};
         a_w_ff[0] <= {req_bus.cx[COORD_W-1], req_bus.cx}
                    - {req_bus.bx[COORD_W-1], req_bus.bx};
         a_w_ff[1] <= {req_bus.cy[COORD_W-1], req_bus.cy}
                    - {req_bus.by_coord[COORD_W-1], req_bus.by_coord};
         a_w_ff[2] <= {req_bus.cz[COORD_W-1], req_bus.cz}
                    - {req_bus.bz[COORD_W-1], req_bus.bz};
         b_id_ff <= a_id_ff;
         b_p_ff <= b_p_in;
         b_q_ff <= b_q_in;
         b_s_ff <= b_s_in;
         c_car_ff <= c_car_in;
         c_k_ff <= c_k_in;
         d_car_ff <= c_car_ff;
         d_hh_ff <= d_hh_in;
         d_hl_ff <= d_hl_in;
         d_ll_ff <= d_ll_in;
         e_car_ff <= d_car_ff;
         e_sq_ff <= e_sq_in;
         sq_id_ff[0] <= e_car_ff.id;
         sq_nz_ff[0] <= e_car_ff.nz;
         sq_n_ff[0] <= e_sq_ff[0] + e_sq_ff[1] + e_sq_ff[2];
         sq_rem_ff[0] <= '0;
         sq_root_ff[0] <= '0;
         er_n_ff[0] <= e_car_ff.esq;
         er_rem_ff[0] <= '0;
         er_root_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < AREA_W; s++) begin : g_root
      logic [AREA_REM_W-1:0] rem2, trial;
      logic take;
      logic [2:0][ESQ_W-1:0] en_in;
      logic [2:0][EDGE_REM_W-1:0] erem_in;
      logic [2:0][EDGE_W-1:0] eroot_in;
      always_comb begin
         rem2  = {sq_rem_ff[s][AREA_REM_W-3:0], sq_n_ff[s][KSQ_W-1 -: 2]};
         trial = AREA_REM_W'({sq_root_ff[s], 2'b01});
         take  = (rem2 >= trial);
         en_in = er_n_ff[s];
         erem_in = er_rem_ff[s];
         eroot_in = er_root_ff[s];
         if (s < EDGE_W) begin
            for (int j = 0; j < 3; j++) begin
               logic [EDGE_REM_W-1:0] er2, et;
               er2 = {er_rem_ff[s][j][EDGE_REM_W-3:0], er_n_ff[s][j][ESQ_W-1 -: 2]};
               et  = EDGE_REM_W'({er_root_ff[s][j], 2'b01});
               en_in[j] = er_n_ff[s][j] << 2;
               if (er2 >= et) begin
                  erem_in[j]  = er2 - et;
                  eroot_in[j] = {er_root_ff[s][j][EDGE_W-2:0], 1'b1};
               end else begin
                  erem_in[j]  = er2;
                  eroot_in[j] = {er_root_ff[s][j][EDGE_W-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[s+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[s+1] <= sq_v_ff[s];
         end
         if (en) begin
            sq_id_ff[s+1]   <= sq_id_ff[s];
            sq_nz_ff[s+1]   <= sq_nz_ff[s];
            sq_n_ff[s+1]    <= sq_n_ff[s] << 2;
            sq_rem_ff[s+1]  <= take ? rem2 - trial : rem2;
            sq_root_ff[s+1] <= {sq_root_ff[s][AREA_W-2:0], take};
            er_n_ff[s+1]    <= en_in;
            er_rem_ff[s+1]  <= erem_in;
            er_root_ff[s+1] <= eroot_in;
         end
      end
   end

   assign perim_in = PERIM_W'(er_root_ff[AREA_W][0]) + PERIM_W'(er_root_ff[AREA_W][1])
                   + PERIM_W'(er_root_ff[AREA_W][2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= sq_v_ff[AREA_W];
      end
      if (en) begin
         dv_id_ff[0]  <= sq_id_ff[AREA_W];
         dv_nz_ff[0]  <= sq_nz_ff[AREA_W];
         dv_a_ff[0]   <= sq_root_ff[AREA_W];
         dv_rem_ff[0] <= '0;
         dv_quo_ff[0] <= '0;
         dv_d_ff[0]   <= perim_in;
      end
   end

   for (genvar s = 0; s < AREA_W; s++) begin : g_div
      logic [DIV_REM_W-1:0] rem2, dvs;
      logic take;
      always_comb begin
         rem2 = {dv_rem_ff[s][DIV_REM_W-2:0], dv_a_ff[s][AREA_W-1]};
         dvs  = DIV_REM_W'(dv_d_ff[s]);
         take = (rem2 >= dvs);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[s+1] <= 1'b0;
         end else if (en) begin
            dv_v_ff[s+1] <= dv_v_ff[s];
         end
         if (en) begin
            dv_id_ff[s+1]  <= dv_id_ff[s];
            dv_nz_ff[s+1]  <= dv_nz_ff[s];
            dv_a_ff[s+1]   <= dv_a_ff[s] << 1;
            dv_rem_ff[s+1] <= take ? rem2 - dvs : rem2;
            dv_quo_ff[s+1] <= {dv_quo_ff[s][AREA_W-2:0], take};
            dv_d_ff[s+1]   <= dv_d_ff[s];
         end
      end
   end

   assign fin_pass = dv_v_ff[AREA_W] && dv_nz_ff[AREA_W]
                  && (dv_quo_ff[AREA_W][AREA_W-1:VALUE_W] == '0)
                  && (dv_quo_ff[AREA_W][VALUE_W-1:0] <= thr_ff);
   assign push = en && fin_pass;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         f_id_ff[wr_ptr_ff]  <= dv_id_ff[AREA_W];
         f_val_ff[wr_ptr_ff] <= dv_quo_ff[AREA_W][VALUE_W-1:0];
      end
   end

   assign rsp_bus.valid        = (cnt_ff != 2'd0);
   assign rsp_bus.sliver_id    = f_id_ff[rd_ptr_ff];
   assign rsp_bus.sliver_value = f_val_ff[rd_ptr_ff];

   `STDET_ASSERT_NOW(a_cnt_max, 1'b1, cnt_ff <= 2'd2)
   `STDET_ASSERT_NEXT(a_stall_hold, !en, $stable(sq_v_ff) && $stable(dv_v_ff))
   `STDET_ASSERT_NOW(a_rsp_thr, rsp_bus.valid, rsp_bus.sliver_value <= thr_ff)
   `STDET_ASSERT_NEXT(a_full_no_push, cnt_ff == 2'd2 && !pop, cnt_ff == 2'd2)

endmodule
`default_nettype wire
